// File: design/pld_pkg.sv
package pld_pkg;

    // Widths of the configuration registers and of the result fields
    localparam int CFG_DIST_W   = 24;
    localparam int CFG_MS_W     = 16;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 5;
    localparam int OUT_DATA_W   = 32;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_ENABLE         = 3'd0,
        REG_MAX_DISTANCE   = 3'd1,
        REG_TOLERANCE      = 3'd2,
        REG_CHECK_INTERVAL = 3'd3,
        REG_RETRY_DELAY    = 3'd4,
        REG_RESTART_WINDOW = 3'd5
    } reg_index_t;

    // Reset values of the registers
    localparam logic [CFG_DIST_W-1:0] MAX_DISTANCE_RST   = CFG_DIST_W'(256);
    localparam logic [CFG_DIST_W-1:0] TOLERANCE_RST      = '0;
    localparam logic [CFG_MS_W-1:0]   CHECK_INTERVAL_RST = CFG_MS_W'(100);
    localparam logic [CFG_MS_W-1:0]   RETRY_DELAY_RST    = CFG_MS_W'(1000);
    localparam logic [CFG_MS_W-1:0]   RESTART_WINDOW_RST = CFG_MS_W'(2000);

    // Register contents as seen by the datapath
    typedef struct packed {
        logic                  enable;
        logic [CFG_DIST_W-1:0] max_distance;
        logic [CFG_DIST_W-1:0] tolerance;
        logic [CFG_MS_W-1:0]   check_interval_ms;
        logic [CFG_MS_W-1:0]   retry_delay_ms;
        logic [CFG_MS_W-1:0]   restart_window_ms;
    } cfg_t;

endpackage

// File: design/proximity_leave_detector.sv
// Proximity leave detector: one sample per frame goes in on s_*, one result
// comes out on m_* for every sample, in order. A sample is captured in an input
// register, evaluated against the session state by a single compare/add pass
// and written to the result register; barring back-pressure from m_tready, a
// new sample is taken every clock and each result is presented on m_* from
// the result register. Registers (APB, byte address 4*index):
// enable, max_distance, tolerance, check_interval_ms, retry_delay_ms,
// restart_window_ms; write them only while no sample is in flight.
module proximity_leave_detector
    import pld_pkg::*;
#(
    parameter int DISTANCE_WIDTH = 24,
    parameter int PARTNER_WIDTH  = 32,
    parameter int TIME_WIDTH     = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // session_active, partner_id, time_ms, camera_flag, distance_valid,
    // distance, zero fill
    input  logic [(((3+PARTNER_WIDTH+TIME_WIDTH+DISTANCE_WIDTH)+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // request_exit, in_session, session_ignored, session_armed,
    // tracked_minimum[23:0], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int PW    = PARTNER_WIDTH;
    localparam int TW    = TIME_WIDTH;
    localparam int DW    = DISTANCE_WIDTH;
    localparam int CMP_W = ((DW > CFG_DIST_W) ? DW : CFG_DIST_W) + 1;

    localparam int P_LSB = 1;
    localparam int T_LSB = P_LSB + PW;
    localparam int C_BIT = T_LSB + TW;
    localparam int V_BIT = C_BIT + 1;
    localparam int D_LSB = V_BIT + 1;

    cfg_t cfg;

    pld_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic          in_valid_reg;
    logic          active_reg;
    logic [PW-1:0] partner_reg;
    logic [TW-1:0] now_reg;
    logic          camera_reg;
    logic          dvalid_reg;
    logic [DW-1:0] dist_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  req_out_reg;
    logic                  sess_out_reg;
    logic                  ign_out_reg;
    logic                  arm_out_reg;
    logic [CFG_DIST_W-1:0] min_out_reg;

    // Session state
    logic          conv_reg, conv_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic          armed_reg, armed_next;
    logic          ign_reg, ign_next;
    logic          far_reg, far_next;
    logic [DW-1:0] min_reg, min_next;
    logic [TW-1:0] nct_reg, nct_next;
    logic [PW-1:0] lexp_reg, lexp_next;
    logic [TW-1:0] ltime_reg, ltime_next;
    logic          rec_reg, rec_next;
    logic          req_next;

    logic advance;
    logic step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({min_out_reg, arm_out_reg, ign_out_reg,
                                   sess_out_reg, req_out_reg});

    // Capture input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            active_reg  <= s_tdata[0];
            partner_reg <= s_tdata[T_LSB-1:P_LSB];
            now_reg     <= s_tdata[C_BIT-1:T_LSB];
            camera_reg  <= s_tdata[C_BIT];
            dvalid_reg  <= s_tdata[V_BIT];
            dist_reg    <= s_tdata[D_LSB+DW-1:D_LSB];
        end
    end

    // Session update for one sample
    always_comb
    begin
        logic          start;
        logic          restarted;
        logic [TW-1:0] since_exit;
        logic [TW-1:0] to_check;
        logic [CMP_W-1:0] dist_x;
        logic [CMP_W-1:0] max_x;
        logic [CMP_W-1:0] min_x;
        logic [CMP_W-1:0] bound_x;
        logic          beyond;
        logic          leaving;

        conv_next  = conv_reg;
        cur_next   = cur_reg;
        armed_next = armed_reg;
        ign_next   = ign_reg;
        far_next   = far_reg;
        min_next   = min_reg;
        nct_next   = nct_reg;
        lexp_next  = lexp_reg;
        ltime_next = ltime_reg;
        rec_next   = rec_reg;
        req_next   = 1'b0;
        min_x      = '0;
        bound_x    = '0;
        leaving    = 1'b0;
        to_check   = '0;

        start      = !conv_reg || (partner_reg != cur_reg);
        since_exit = now_reg - ltime_reg;
        restarted  = rec_reg && (partner_reg == lexp_reg) &&
                     (since_exit[TW-1] || (since_exit < TW'(cfg.restart_window_ms)));
        dist_x     = CMP_W'(dist_reg);
        max_x      = CMP_W'(cfg.max_distance);
        beyond     = dist_x > max_x;

        if (cfg.enable)
        begin
            if (!active_reg)
            begin
                conv_next = 1'b0;
            end
            else
            begin
                // new session on open or partner change
                if (start)
                begin
                    conv_next  = 1'b1;
                    cur_next   = partner_reg;
                    armed_next = 1'b0;
                    far_next   = 1'b0;
                    min_next   = '0;
                    ign_next   = restarted || camera_reg;
                    nct_next   = now_reg;
                end

                min_x    = CMP_W'(min_next);
                bound_x  = min_x + CMP_W'(cfg.tolerance);
                leaving  = !far_next || (dist_x > bound_x);
                to_check = now_reg - nct_next;

                // evaluation slot
                if (!ign_next && !to_check[TW-1])
                begin
                    nct_next = now_reg + TW'(cfg.check_interval_ms);
                    if (dvalid_reg)
                    begin
                        if (!armed_next)
                        begin
                            armed_next = 1'b1;
                            min_next   = dist_reg;
                            far_next   = beyond;
                        end
                        else if (beyond && leaving)
                        begin
                            lexp_next  = partner_reg;
                            ltime_next = now_reg;
                            rec_next   = 1'b1;
                            nct_next   = now_reg + TW'(cfg.retry_delay_ms);
                            req_next   = 1'b1;
                        end
                        else if (dist_x < min_x)
                        begin
                            min_next = dist_reg;
                        end
                    end
                end
            end
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg      <= 1'b0;
            cur_reg       <= '0;
            armed_reg     <= 1'b0;
            ign_reg       <= 1'b0;
            far_reg       <= 1'b0;
            min_reg       <= '0;
            nct_reg       <= '0;
            lexp_reg      <= '0;
            ltime_reg     <= '0;
            rec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                conv_reg  <= conv_next;
                cur_reg   <= cur_next;
                armed_reg <= armed_next;
                ign_reg   <= ign_next;
                far_reg   <= far_next;
                min_reg   <= min_next;
                nct_reg   <= nct_next;
                lexp_reg  <= lexp_next;
                ltime_reg <= ltime_next;
                rec_reg   <= rec_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            req_out_reg  <= req_next;
            sess_out_reg <= conv_next;
            ign_out_reg  <= conv_next && ign_next;
            arm_out_reg  <= conv_next && armed_next;
            min_out_reg  <= conv_next ? CFG_DIST_W'(min_next) : '0;
        end
    end

`ifndef SYNTHESIS
    // An exit request always belongs to a live, tracked session
    assert property (@(posedge clk) disable iff (!rst_n)
        step && req_next |-> conv_next && armed_next && !ign_next)
        else $error("exit request outside an armed session");

    // Detector off leaves the session state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.enable |=> $stable(conv_reg) && $stable(rec_reg) && !req_out_reg)
        else $error("state changed while detector disabled");

    // A request records the exit partner and time
    assert property (@(posedge clk) disable iff (!rst_n)
        step && req_next |=> rec_reg && (lexp_reg == $past(partner_reg))
                              && (ltime_reg == $past(now_reg)))
        else $error("exit not recorded");

    // Session flags in a result only while a session is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (ign_out_reg || arm_out_reg || req_out_reg) |-> sess_out_reg)
        else $error("session flags without a session");
`endif

endmodule

// File: design/pld_cfg_regs.sv
module pld_cfg_regs
    import pld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.max_distance      <= MAX_DISTANCE_RST;
            cfg_reg.tolerance         <= TOLERANCE_RST;
            cfg_reg.check_interval_ms <= CHECK_INTERVAL_RST;
            cfg_reg.retry_delay_ms    <= RETRY_DELAY_RST;
            cfg_reg.restart_window_ms <= RESTART_WINDOW_RST;
        end
        else if (wr_en)
        begin
            case (index)
                REG_ENABLE:         cfg_reg.enable            <= pwdata[0];
                REG_MAX_DISTANCE:   cfg_reg.max_distance      <= pwdata[CFG_DIST_W-1:0];
                REG_TOLERANCE:      cfg_reg.tolerance         <= pwdata[CFG_DIST_W-1:0];
                REG_CHECK_INTERVAL: cfg_reg.check_interval_ms <= pwdata[CFG_MS_W-1:0];
                REG_RETRY_DELAY:    cfg_reg.retry_delay_ms    <= pwdata[CFG_MS_W-1:0];
                REG_RESTART_WINDOW: cfg_reg.restart_window_ms <= pwdata[CFG_MS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        case (index)
            REG_ENABLE:         prdata = APB_DATA_W'(cfg_reg.enable);
            REG_MAX_DISTANCE:   prdata = APB_DATA_W'(cfg_reg.max_distance);
            REG_TOLERANCE:      prdata = APB_DATA_W'(cfg_reg.tolerance);
            REG_CHECK_INTERVAL: prdata = APB_DATA_W'(cfg_reg.check_interval_ms);
            REG_RETRY_DELAY:    prdata = APB_DATA_W'(cfg_reg.retry_delay_ms);
            REG_RESTART_WINDOW: prdata = APB_DATA_W'(cfg_reg.restart_window_ms);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pld_pkg::*;

    localparam int SAMPLE_W   = 3 + 32 + 32 + 24;
    localparam int IN_W       = ((SAMPLE_W + 7) / 8) * 8;
    localparam int QUIET_MAX  = 3000;
    localparam int SQUEEZE_CY = 300;

    // One input sample, first field in the lowest bit
    typedef struct packed {
        logic [23:0] distance;
        logic        dist_valid;
        logic        camera;
        logic [31:0] stamp_ms;
        logic [31:0] partner;
        logic        active;
    } sample_t;

    // One result, first field in the lowest bit
    typedef struct packed {
        logic [23:0] minimum;
        logic        armed;
        logic        ignored;
        logic        in_session;
        logic        leave_req;
    } verdict_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // session_active, partner_id, time_ms, camera_flag, distance_valid,
    // distance, zero fill
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // request_exit, in_session, session_ignored, session_armed,
    // tracked_minimum[23:0], zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    proximity_leave_detector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Stimulus bookkeeping
    logic [IN_W-1:0] pending_samples[$];
    verdict_t        expected_verdicts[$];
    int              samples_queued   = 0;
    int              results_seen     = 0;
    int              mismatches       = 0;
    int              exits_predicted  = 0;
    int              settings_used    = 0;
    bit              gaps_on          = 1'b1;
    bit              squeeze_on       = 1'b0;
    int              quiet_cycles     = 0;

    // Settings as last written, used to shape the stimulus
    int unsigned set_max    = 256;
    int unsigned set_tol    = 0;
    int unsigned set_ival   = 100;
    int unsigned set_retry  = 1000;
    int unsigned set_window = 2000;
    logic [31:0] clock_ms   = '0;
    logic [31:0] partner_pool[4];

    // Predictor copy of the registers and the session state
    cfg_t        cfg_q;
    logic        sess_open, sess_armed, sess_ignored, sess_far, exit_seen;
    logic [31:0] sess_partner, next_check, exit_partner, exit_time;
    logic [23:0] sess_min;
    verdict_t    fresh_verdict;

    function automatic verdict_t predict_verdict(sample_t s);
        verdict_t    v;
        logic [31:0] d;
        logic        restarted;
        logic        leaving;
        logic [24:0] reach;
        v = '0;
        if (cfg_q.enable) begin
            if (!s.active) begin
                sess_open = 1'b0;
            end
            else begin
                // new session on open or partner change
                if (!sess_open || s.partner != sess_partner) begin
                    restarted = 1'b0;
                    if (exit_seen && s.partner == exit_partner) begin
                        d = s.stamp_ms - exit_time;
                        restarted = d[31] || (d < {16'b0, cfg_q.restart_window_ms});
                    end
                    sess_open    = 1'b1;
                    sess_partner = s.partner;
                    sess_armed   = 1'b0;
                    sess_far     = 1'b0;
                    sess_min     = '0;
                    sess_ignored = restarted || s.camera;
                    next_check   = s.stamp_ms;
                end
                // evaluation slot, wrap-safe compare
                d = s.stamp_ms - next_check;
                if (!sess_ignored && !d[31]) begin
                    next_check = s.stamp_ms + {16'b0, cfg_q.check_interval_ms};
                    if (s.dist_valid) begin
                        if (!sess_armed) begin
                            sess_armed = 1'b1;
                            sess_min   = s.distance;
                            sess_far   = s.distance > cfg_q.max_distance;
                        end
                        else begin
                            reach   = {1'b0, sess_min} + {1'b0, cfg_q.tolerance};
                            leaving = !sess_far || ({1'b0, s.distance} > reach);
                            if (s.distance > cfg_q.max_distance && leaving) begin
                                exit_partner = s.partner;
                                exit_time    = s.stamp_ms;
                                exit_seen    = 1'b1;
                                next_check   = s.stamp_ms + {16'b0, cfg_q.retry_delay_ms};
                                v.leave_req  = 1'b1;
                            end
                            else if (s.distance < sess_min) begin
                                sess_min = s.distance;
                            end
                        end
                    end
                end
            end
        end
        v.in_session = sess_open;
        v.ignored    = sess_open && sess_ignored;
        v.armed      = sess_open && sess_armed;
        v.minimum    = sess_open ? sess_min : '0;
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Register shadow and prediction at every input transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_q.enable            = 1'b0;
            cfg_q.max_distance      = MAX_DISTANCE_RST;
            cfg_q.tolerance         = TOLERANCE_RST;
            cfg_q.check_interval_ms = CHECK_INTERVAL_RST;
            cfg_q.retry_delay_ms    = RETRY_DELAY_RST;
            cfg_q.restart_window_ms = RESTART_WINDOW_RST;
            sess_open    = 1'b0;
            sess_armed   = 1'b0;
            sess_ignored = 1'b0;
            sess_far     = 1'b0;
            exit_seen    = 1'b0;
            sess_partner = '0;
            next_check   = '0;
            exit_partner = '0;
            exit_time    = '0;
            sess_min     = '0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[4:2]))
                    REG_ENABLE:         cfg_q.enable            = pwdata[0];
                    REG_MAX_DISTANCE:   cfg_q.max_distance      = pwdata[23:0];
                    REG_TOLERANCE:      cfg_q.tolerance         = pwdata[23:0];
                    REG_CHECK_INTERVAL: cfg_q.check_interval_ms = pwdata[15:0];
                    REG_RETRY_DELAY:    cfg_q.retry_delay_ms    = pwdata[15:0];
                    REG_RESTART_WINDOW: cfg_q.restart_window_ms = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                fresh_verdict = predict_verdict(sample_t'(s_tdata[SAMPLE_W-1:0]));
                expected_verdicts.push_back(fresh_verdict);
                if (fresh_verdict.leave_req)
                    exits_predicted++;
            end
        end
    end

    // Sender: gap or next pending sample
    int gap_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_samples.size() != 0) begin
                s_tdata  <= pending_samples.pop_front();
                s_tvalid <= 1'b1;
                gap_left <= pick_gap();
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off during the squeeze phase
    int stall_left   = 0;
    bit squeeze_done = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (squeeze_on && !squeeze_done) begin
            m_tready     <= 1'b0;
            stall_left   <= SQUEEZE_CY;
            squeeze_done <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 99) < 15) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Result check against the oldest expectation
    verdict_t got_verdict, want_verdict;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_verdict = verdict_t'(m_tdata[27:0]);
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, '0);
            end
            else begin
                want_verdict = expected_verdicts.pop_front();
                if (got_verdict.leave_req !== want_verdict.leave_req)
                    report_mismatch("request_exit", 32'(got_verdict.leave_req),
                                    32'(want_verdict.leave_req));
                if (got_verdict.in_session !== want_verdict.in_session)
                    report_mismatch("in_session", 32'(got_verdict.in_session),
                                    32'(want_verdict.in_session));
                if (got_verdict.ignored !== want_verdict.ignored)
                    report_mismatch("session_ignored", 32'(got_verdict.ignored),
                                    32'(want_verdict.ignored));
                if (got_verdict.armed !== want_verdict.armed)
                    report_mismatch("session_armed", 32'(got_verdict.armed),
                                    32'(want_verdict.armed));
                if (got_verdict.minimum !== want_verdict.minimum)
                    report_mismatch("tracked_minimum", 32'(got_verdict.minimum),
                                    32'(want_verdict.minimum));
            end
            results_seen++;
        end
    end

    // Watchdog: cycles without any transfer while samples are outstanding
    always @(posedge clk) begin
        if (rst_n && samples_queued != results_seen
                && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("watchdog: no transfer for %0d cycles, %0d results missing",
                         quiet_cycles, samples_queued - results_seen);
                $display("*** FAILED ***");
                $finish;
            end
        end
        else begin
            quiet_cycles = 0;
        end
    end

    // APB write: setup cycle, then access cycle
    task automatic apb_write(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(bit en, int unsigned dmax, int unsigned tol,
                                  int unsigned ival, int unsigned retry,
                                  int unsigned window);
        apb_write(REG_ENABLE, 32'(en));
        apb_write(REG_MAX_DISTANCE, dmax);
        apb_write(REG_TOLERANCE, tol);
        apb_write(REG_CHECK_INTERVAL, ival);
        apb_write(REG_RETRY_DELAY, retry);
        apb_write(REG_RESTART_WINDOW, window);
        set_max    = dmax;
        set_tol    = tol;
        set_ival   = ival;
        set_retry  = retry;
        set_window = window;
        settings_used++;
    endtask

    task automatic push_sample(bit act, logic [31:0] partner, logic [31:0] stamp,
                               bit cam, bit valid, logic [23:0] dist_in);
        sample_t s;
        s.active     = act;
        s.partner    = partner;
        s.stamp_ms   = stamp;
        s.camera     = cam;
        s.dist_valid = valid;
        s.distance   = dist_in;
        pending_samples.push_back(IN_W'(s));
        samples_queued++;
    endtask

    // Wait until every queued sample has produced its result
    task automatic drain();
        while (results_seen != samples_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Time advance scaled to the current settings
    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(set_ival / 2, set_ival * 2 + 1);
        if (r < 70) return $urandom_range(0, set_ival / 2);
        if (r < 85) return $urandom_range(set_retry / 2, set_retry * 2 + 1);
        if (r < 92) return $urandom_range(set_window / 2, set_window + set_window / 2);
        if (r < 96) return 32'd0;
        return $urandom;
    endfunction

    // A session with one partner, partner drifting away with some noise
    task automatic queue_session(logic [31:0] partner, int len, bit cam);
        logic [31:0] span;
        int unsigned climb;
        int          r;
        span  = $urandom_range(0, set_max + set_max / 2);
        climb = set_max / 8 + set_tol / 4 + 1;
        for (int k = 0; k < len; k++) begin
            clock_ms = clock_ms + pick_step();
            r = $urandom_range(0, 99);
            if (r < 70)
                span = span + $urandom_range(0, climb);
            else if (r < 85)
                span = span - ((span > climb) ? $urandom_range(0, climb) : span);
            else if (r < 92)
                span = set_max + $urandom_range(0, 1);
            else if (r < 96)
                span = 32'hFFFFFF;
            else
                span = $urandom_range(0, 3);
            if (span > 32'hFFFFFF)
                span = 32'hFFFFFF;
            push_sample(1'b1, partner, clock_ms,
                        (k == 0) ? cam : 1'($urandom_range(0, 1)),
                        $urandom_range(0, 99) < 90, span[23:0]);
        end
    endtask

    task automatic queue_random_phase(int count);
        int          left;
        int          r;
        int          len;
        logic [31:0] partner;
        logic [31:0] last_partner;
        left         = count;
        last_partner = partner_pool[0];
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                // well-formed session, mostly with a pool partner
                partner = ($urandom_range(0, 4) == 0) ? $urandom
                                                      : partner_pool[$urandom_range(0, 3)];
                len = $urandom_range(4, 20);
                queue_session(partner, len, $urandom_range(0, 9) == 0);
                last_partner = partner;
                left -= len;
            end
            else if (r < 82) begin
                // close, then come back to the same partner soon or in the past
                push_sample(1'b0, $urandom, clock_ms, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 24'($urandom));
                if ($urandom_range(0, 3) == 0)
                    clock_ms = clock_ms - $urandom_range(1, 3000);
                else
                    clock_ms = clock_ms + $urandom_range(0, set_window + 10);
                len = $urandom_range(3, 10);
                queue_session(last_partner, len, 1'b0);
                left -= len + 1;
            end
            else if (r < 92) begin
                // inactive samples with random content
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    clock_ms = clock_ms + pick_step();
                    push_sample(1'b0, $urandom, clock_ms, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 24'($urandom));
                end
                left -= len;
            end
            else begin
                // noise: every field random
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    push_sample(1'($urandom_range(0, 1)), $urandom, $urandom,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                24'($urandom));
                left -= len;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        partner_pool[0] = 32'h0000_0000;
        partner_pool[1] = 32'hFFFF_FFFF;
        partner_pool[2] = $urandom;
        partner_pool[3] = $urandom;

        // Detector off after reset: state held, no request
        push_sample(1'b1, 32'h1234_5678, 32'd10, 1'b0, 1'b1, 24'hFFFFFF);
        push_sample(1'b1, 32'h1234_5678, 32'd200, 1'b0, 1'b1, 24'd0);
        push_sample(1'b0, 32'd0, 32'd300, 1'b1, 1'b0, 24'd5);
        drain();

        // Directed checks with the default limits written explicitly
        apply_settings(1'b1, 256, 0, 100, 1000, 2000);
        push_sample(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 24'hFFFFFF);
        push_sample(1'b1, 32'd0, 32'd0, 1'b0, 1'b1, 24'd0);       // first session, arms
        push_sample(1'b1, 32'd0, 32'd50, 1'b0, 1'b1, 24'd300);    // before the check slot
        push_sample(1'b1, 32'd0, 32'd100, 1'b0, 1'b1, 24'd300);   // near at open, leaves
        push_sample(1'b1, 32'd0, 32'd600, 1'b0, 1'b1, 24'd400);   // inside retry delay
        push_sample(1'b1, 32'd0, 32'd1100, 1'b0, 1'b1, 24'd100);
        push_sample(1'b0, 32'd0, 32'd1200, 1'b0, 1'b0, 24'd0);
        push_sample(1'b1, 32'd0, 32'd1300, 1'b0, 1'b1, 24'd5000); // restart in window
        push_sample(1'b1, 32'd7, 32'd1400, 1'b1, 1'b1, 24'd5000); // camera at start
        push_sample(1'b1, 32'd8, 32'd1500, 1'b0, 1'b0, 24'd0);    // invalid uses the slot
        push_sample(1'b1, 32'd8, 32'd1550, 1'b0, 1'b1, 24'd1000);
        push_sample(1'b1, 32'd8, 32'd1600, 1'b0, 1'b1, 24'd1000); // far at open
        push_sample(1'b1, 32'd8, 32'd1700, 1'b0, 1'b1, 24'd1000); // not beyond min+tol
        push_sample(1'b1, 32'd8, 32'd1800, 1'b0, 1'b1, 24'd999);  // new minimum
        push_sample(1'b1, 32'd8, 32'd1900, 1'b0, 1'b1, 24'd1000); // leaving again
        push_sample(1'b1, 32'd9, 32'hFFFF_FFF0, 1'b0, 1'b1, 24'd10);
        push_sample(1'b1, 32'd9, 32'h0000_0050, 1'b0, 1'b1, 24'd20);  // across the wrap
        push_sample(1'b1, 32'd9, 32'h0000_0060, 1'b0, 1'b1, 24'd257);
        push_sample(1'b1, 32'd8, 32'h0000_0070, 1'b0, 1'b1, 24'd5);
        push_sample(1'b1, 32'd9, 32'h0000_0040, 1'b0, 1'b1, 24'd5);   // last exit ahead
        push_sample(1'b1, 32'd9, 32'h0001_0000, 1'b0, 1'b1, 24'd0);
        push_sample(1'b1, 32'hA5A5_A5A5, 32'h0002_0000, 1'b0, 1'b1, 24'hFFFFFF);
        push_sample(1'b1, 32'hA5A5_A5A5, 32'h0002_0100, 1'b0, 1'b1, 24'hFFFFFF);
        push_sample(1'b1, 32'hA5A5_A5A5, 32'h0002_0200, 1'b0, 1'b1, 24'd256);
        push_sample(1'b1, 32'h5A5A_5A5A, 32'h0003_0000, 1'b0, 1'b0, 24'd0);
        drain();
        clock_ms = 32'h0004_0000;

        // Random phases over several settings
        for (int p = 0; p < 8; p++) begin
            gaps_on    = (p != 5);
            squeeze_on = (p == 4);
            case (p)
                0: apply_settings(1'b1, 1, 0, 1, 1, 0);
                1: apply_settings(1'b1, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
                2: apply_settings(1'b1, 256, 16, 0, 0, 500);
                3: apply_settings(1'b0, $urandom_range(1, 4096), $urandom_range(0, 512),
                                  $urandom_range(1, 300), $urandom_range(1, 2000),
                                  $urandom_range(0, 3000));
                default: apply_settings(1'b1, $urandom_range(1, 4096), $urandom_range(0, 512),
                                        $urandom_range(1, 300), $urandom_range(1, 2000),
                                        $urandom_range(0, 3000));
            endcase
            queue_random_phase((p == 3) ? 40 : 95);
            drain();
        end

        repeat (8) @(posedge clk);
        while (expected_verdicts.size() != 0) begin
            want_verdict = expected_verdicts.pop_front();
            report_mismatch("result never arrived", '0, 32'(want_verdict));
        end

        $display("Covered %0d samples under %0d register settings, including off, extremes",
                 samples_queued, settings_used);
        $display("and zero intervals; %0d exit requests expected, %0d mismatches.",
                 exits_predicted, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
design/pld_pkg.sv
design/pld_cfg_regs.sv
design/proximity_leave_detector.sv
bench/testbench.sv
